// ===== rtl/core/ovs_pkg.sv =====
// ovs_pkg: operation and status codes, control struct and fixed field widths
// for the ordered value set. No dependencies; every other file imports it.

package ovs_pkg;

	// Field widths of the request and response transactions
	localparam int KIND_W   = 3;
	localparam int IN_VAL_W = 32;
	localparam int POS_W    = 4;
	localparam int CNT_W    = 5;
	localparam int STAT_W   = 2;

	// Operation codes; codes five to seven are no-ops
	typedef enum logic [KIND_W-1:0] {
		K_INSERT = 3'd0,
		K_REMOVE = 3'd1,
		K_LOOKUP = 3'd2,
		K_INC    = 3'd3,
		K_DEC    = 3'd4
	} kind_t;

	// Response status codes
	typedef enum logic [STAT_W-1:0] {
		ST_DONE = 2'd0,
		ST_SAME = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// Broadcast from the sequencer to every cell
	typedef struct packed {
		logic  cmp_en;   // register the match flag
		logic  upd_en;   // apply the operation to the entry
		logic  found;    // value was present
		kind_t kind;
	} cell_ctrl_t;

endpackage

// ===== rtl/core/ovs_if.sv =====
// ovs_if: request and response channel interfaces of the ordered value set.
// Depends on ovs_pkg for the field widths.

interface ovs_req_if import ovs_pkg::*;;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [IN_VAL_W-1:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

interface ovs_rsp_if import ovs_pkg::*;;
	logic              valid;
	logic              ready;
	logic              found;
	logic [POS_W-1:0]  position;
	logic [CNT_W-1:0]  entry_count;
	logic [STAT_W-1:0] status;

	modport source (output valid, output found, output position, output entry_count,
		output status, input ready);
	modport sink   (input valid, input found, input position, input entry_count,
		input status, output ready);
endinterface

// ===== rtl/core/ovs_cell.sv =====
// ovs_cell: one slot of the ordered value set. Holds an entry, compares it with
// the operand and shifts, writes or steps it. Depends on ovs_pkg.

module ovs_cell import ovs_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int VALUE_BITS = 32,
	parameter int IDX        = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cell_ctrl_t                    ctrl,
	input  logic [VALUE_BITS-1:0]         op_value,
	input  logic [$clog2(DEPTH+1)-1:0]    count,
	input  logic [$clog2(DEPTH+1)-1:0]    pos,
	input  logic [VALUE_BITS-1:0]         next_entry,
	output logic [VALUE_BITS-1:0]         entry,
	output logic                          match
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
	localparam logic [CW:0]   MY_NEXT = (CW + 1)'(IDX + 1);

	logic [VALUE_BITS-1:0] entry_q;
	logic                  match_q;
	logic                  occupied;
	logic                  shift_in;
	logic                  write_new;

	assign occupied  = MY_IDX < count;
	assign write_new = (MY_IDX == count) && !ctrl.found;
	// take the neighbour's entry when a value at or below this slot leaves
	assign shift_in  = ctrl.found && (MY_IDX >= pos) && (MY_NEXT < {1'b0, count});

	// match flag, registered in the cycle after the operand is latched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.cmp_en) begin
			match_q <= occupied && (entry_q == op_value);
		end
	end

	// entry update
	always_ff @(posedge clk) begin
		if (ctrl.upd_en) begin
			case (ctrl.kind)
				K_INSERT: begin
					if (write_new)
						entry_q <= op_value;
				end
				K_REMOVE: begin
					if (shift_in)
						entry_q <= next_entry;
				end
				K_INC: begin
					if (occupied)
						entry_q <= entry_q + 1'b1;
				end
				K_DEC: begin
					if (occupied)
						entry_q <= entry_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

// ===== rtl/core/ordered_value_set_core.sv =====
// ordered_value_set_core: top level of the ordered value set, a row of ovs_cell
// slots driven by a small sequencer. Depends on ovs_pkg, ovs_if and ovs_cell.
//
// Usage:
//   req carries one operation per transaction: kind (insert, remove, lookup,
//   increment all, decrement all) and a 32-bit value. rsp returns exactly one
//   transaction per request: found, position, entry_count and status.
//   Timing: a request is taken while the sequencer is idle; in the compare state
//   every cell registers its compare of the entry with the operand, and in the
//   update state the match vector is encoded, the cells shift, write or step
//   their entries and the response is registered.
//   A new request is taken only after the current one has left the update
//   state; req.ready is high only while the sequencer is idle.
//   A response waiting in the output register does not block the next request;
//   if rsp.ready is low when the next update is due, the sequencer holds in
//   the update cycle until the register frees.
//   Reset empties the store (entry count zero) and drops any pending response;
//   entries themselves are not cleared, since only occupied slots are read.
//   An insert into a full store is dropped and reported as full.

module ordered_value_set_core import ovs_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	ovs_req_if.sink      req,
	ovs_rsp_if.source    rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_UPD
	} state_t;

	state_t                state_q;
	kind_t                 kind_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [CW-1:0]         count_q;

	logic                  rsp_valid_q;
	logic                  rsp_found_q;
	logic [POS_W-1:0]      rsp_pos_q;
	logic [CNT_W-1:0]      rsp_cnt_q;
	status_t               rsp_stat_q;

	logic [VALUE_BITS-1:0] ent   [DEPTH];
	logic [VALUE_BITS-1:0] nxt   [DEPTH];
	logic [DEPTH-1:0]      match;
	logic                  op_cmp;
	logic                  hit;
	logic [CW-1:0]         pos_enc;
	logic                  upd_go;
	logic                  full;
	logic [CW-1:0]         count_nx;
	status_t               stat_nx;
	cell_ctrl_t            ctrl;
	logic [63:0]           val_wide;
	logic [31:0]           pos_wide;
	logic [31:0]           cnt_wide;

	// operand cut or extended to the stored width
	assign val_wide = 64'(req.value);

	assign req.ready = (state_q == S_IDLE);
	assign upd_go    = (state_q == S_UPD) && (!rsp_valid_q || rsp.ready);
	assign full      = (count_q == CW'(DEPTH));
	// only insert, remove and lookup search the store
	assign op_cmp    = (kind_q == K_INSERT) || (kind_q == K_REMOVE) ||
		(kind_q == K_LOOKUP);
	assign hit       = op_cmp && (|match);

	// encode the one-hot match vector (entries are distinct)
	always_comb begin
		pos_enc = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (match[i] && op_cmp)
				pos_enc = pos_enc | CW'(i);
		end
	end

	// new count and status
	always_comb begin
		count_nx = count_q;
		stat_nx  = ST_DONE;
		case (kind_q)
			K_INSERT: begin
				if (hit)
					stat_nx = ST_SAME;
				else if (full)
					stat_nx = ST_FULL;
				else
					count_nx = count_q + 1'b1;
			end
			K_REMOVE: begin
				if (hit)
					count_nx = count_q - 1'b1;
				else
					stat_nx = ST_SAME;
			end
			K_LOOKUP: begin
				if (!hit)
					stat_nx = ST_SAME;
			end
			K_INC, K_DEC: begin
				stat_nx = ST_DONE;
			end
			default: begin
				stat_nx = ST_SAME;
			end
		endcase
	end

	assign ctrl.cmp_en = (state_q == S_CMP);
	assign ctrl.upd_en = upd_go;
	assign ctrl.found  = hit;
	assign ctrl.kind   = kind_q;

	// a hit reports a position only for insert, remove and lookup
	assign pos_wide = 32'(pos_enc);
	assign cnt_wide = 32'(count_nx);

	// sequencer, store count and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready && !upd_go)
				rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid)
						state_q <= S_CMP;
				end
				S_CMP: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (upd_go) begin
						state_q     <= S_IDLE;
						count_q     <= count_nx;
						rsp_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// operand and response payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_q  <= kind_t'(req.kind);
			value_q <= val_wide[VALUE_BITS-1:0];
		end
		if (upd_go) begin
			rsp_found_q <= hit;
			rsp_pos_q   <= pos_wide[POS_W-1:0];
			rsp_cnt_q   <= cnt_wide[CNT_W-1:0];
			rsp_stat_q  <= stat_nx;
		end
	end

	// row of cells; each takes its upper neighbour's entry on a remove
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		if (g < DEPTH - 1) begin : g_mid
			assign nxt[g] = ent[g+1];
		end else begin : g_last
			assign nxt[g] = '0;
		end

		ovs_cell #(
			.DEPTH      (DEPTH),
			.VALUE_BITS (VALUE_BITS),
			.IDX        (g)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.op_value   (value_q),
			.count      (count_q),
			.pos        (pos_enc),
			.next_entry (nxt[g]),
			.entry      (ent[g]),
			.match      (match[g])
		);
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.found       = rsp_found_q;
	assign rsp.position    = rsp_pos_q;
	assign rsp.entry_count = rsp_cnt_q;
	assign rsp.status      = rsp_stat_q;

endmodule

// ===== rtl/core/ovs_chk.sv =====
// ovs_chk: port-level checks of the ordered value set, bound to
// ordered_value_set_core. Depends on ovs_pkg for codes and widths.

module ovs_chk import ovs_pkg::*; #(
	parameter int DEPTH = 16
) (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic              rsp_found,
	input logic [POS_W-1:0]  rsp_position,
	input logic [CNT_W-1:0]  rsp_entry_count,
	input logic [STAT_W-1:0] rsp_status
);

	// a stalled response holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) &&
		$stable(rsp_position) && $stable(rsp_entry_count) && $stable(rsp_status))
		else $error("response changed while stalled");

	// one request at a time: ready drops after a transaction
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while one is in progress");

	// a miss reports position zero
	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_position == '0)
		else $error("position given without a hit");

	// a dropped insert means a full store and no hit
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |->
		!rsp_found && rsp_entry_count == CNT_W'(DEPTH))
		else $error("full status with inconsistent fields");

	// the count stays in range and the status is one of the defined codes
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_entry_count <= CNT_W'(DEPTH) &&
		(rsp_status == ST_DONE || rsp_status == ST_SAME || rsp_status == ST_FULL))
		else $error("count or status out of range");

endmodule

bind ordered_value_set_core ovs_chk #(
	.DEPTH (DEPTH)
) u_ovs_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_found       (rsp.found),
	.rsp_position    (rsp.position),
	.rsp_entry_count (rsp.entry_count),
	.rsp_status      (rsp.status)
);
